FILE: rtl/h2b_pkg.sv
// Shared types, constants and character functions for the hex to Base64 converter.
// Used by every module in rtl/ and by the port checker; depends on nothing.
package h2b_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_BAD_CHAR  = 2'd1;
	localparam logic [1:0] STATUS_ODD_COUNT = 2'd2;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef struct packed {
		logic [7:0] hex_char;
		logic       end_of_message;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last_of_message;
		logic [1:0] status;
	} out_word_t;

	// One unit of work for the back end: a Base64 group or a single error word.
	typedef struct packed {
		logic        is_err;
		logic [1:0]  status;
		logic [23:0] group;
		logic [1:0]  pad_count;
		logic        last;
	} job_t;

	// Returns {valid, nibble}.
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		case (c) inside
			[8'h30:8'h39]: r = {1'b1, 4'(c - 8'h30)};
			[8'h61:8'h66]: r = {1'b1, 4'(c - 8'h57)};
			[8'h41:8'h46]: r = {1'b1, 4'(c - 8'h37)};
			default:       r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] r;
		r = 8'd0;
		case (v) inside
			[6'd0:6'd25]:  r = 8'h41 + {2'b00, v};
			[6'd26:6'd51]: r = 8'h61 + {2'b00, v} - 8'd26;
			[6'd52:6'd61]: r = 8'h30 + {2'b00, v} - 8'd52;
			6'd62:         r = 8'h2B;
			default:       r = 8'h2F;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/h2b_front.sv
// Front end: takes hex characters, tracks nibble and byte grouping, issues jobs.
// Depends on h2b_pkg; feeds h2b_queue.
module h2b_front import h2b_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     hex_valid,
	output logic     hex_ready,
	input  in_word_t hex_word,
	input  logic     queue_full,
	output logic     push,
	output job_t     push_job
);

	logic [3:0]  pending_q;
	logic        waiting_q;
	logic [15:0] held_q;
	logic [1:0]  count_q;
	logic        discard_q;

	logic [3:0]  pending_d;
	logic        waiting_d;
	logic [15:0] held_d;
	logic [1:0]  count_d;
	logic        discard_d;

	logic        accept;
	logic [4:0]  nib;
	logic        eom;
	logic [7:0]  byte_val;

	assign hex_ready = !queue_full;
	assign accept    = hex_valid && hex_ready;
	assign nib       = hex_nibble(hex_word.hex_char);
	assign eom       = hex_word.end_of_message;
	assign byte_val  = {pending_q, nib[3:0]};

	always_comb begin
		pending_d = pending_q;
		waiting_d = waiting_q;
		held_d    = held_q;
		count_d   = count_q;
		discard_d = discard_q;
		push      = 1'b0;
		push_job  = '{is_err: 1'b0, status: STATUS_OK, group: 24'd0,
			pad_count: 2'd0, last: eom};
		if (accept) begin
			if (discard_q) begin
				if (eom) begin
					discard_d = 1'b0;
					pending_d = 4'd0;
					waiting_d = 1'b0;
					held_d    = 16'd0;
					count_d   = 2'd0;
				end
			end else if (eom && !waiting_q) begin
				pending_d       = 4'd0;
				waiting_d       = 1'b0;
				held_d          = 16'd0;
				count_d         = 2'd0;
				push            = 1'b1;
				push_job.is_err = 1'b1;
				push_job.status = STATUS_ODD_COUNT;
				push_job.last   = 1'b1;
			end else if (!nib[4]) begin
				pending_d       = 4'd0;
				waiting_d       = 1'b0;
				held_d          = 16'd0;
				count_d         = 2'd0;
				discard_d       = !eom;
				push            = 1'b1;
				push_job.is_err = 1'b1;
				push_job.status = STATUS_BAD_CHAR;
				push_job.last   = 1'b1;
			end else if (!waiting_q) begin
				pending_d = nib[3:0];
				waiting_d = 1'b1;
			end else begin
				pending_d = 4'd0;
				waiting_d = 1'b0;
				if (count_q >= 2'd2) begin
					push           = 1'b1;
					push_job.group = {held_q, byte_val};
					held_d         = 16'd0;
					count_d        = 2'd0;
				end else if (eom) begin
					push = 1'b1;
					if (count_q == 2'd0) begin
						push_job.group     = {byte_val, 16'd0};
						push_job.pad_count = 2'd2;
					end else begin
						push_job.group     = {held_q[7:0], byte_val, 8'd0};
						push_job.pad_count = 2'd1;
					end
					held_d  = 16'd0;
					count_d = 2'd0;
				end else begin
					held_d  = {held_q[7:0], byte_val};
					count_d = count_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 4'd0;
			waiting_q <= 1'b0;
			held_q    <= 16'd0;
			count_q   <= 2'd0;
			discard_q <= 1'b0;
		end else begin
			pending_q <= pending_d;
			waiting_q <= waiting_d;
			held_q    <= held_d;
			count_q   <= count_d;
			discard_q <= discard_d;
		end
	end

endmodule

FILE: rtl/h2b_queue.sv
// Job queue between the front and back ends, QUEUE_DEPTH entries deep.
// Depends on h2b_pkg.
module h2b_queue import h2b_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t head_job,
	output logic empty
);

	localparam logic [QUEUE_AW:0] DEPTH_CNT = (QUEUE_AW + 1)'(QUEUE_DEPTH);

	job_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full     = (count_q == DEPTH_CNT);
	assign empty    = (count_q == '0);
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/h2b_back.sv
// Back end: takes jobs from the queue and sends them out one word per cycle while b64_ready allows.
// Depends on h2b_pkg; fed by h2b_queue.
module h2b_back import h2b_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      queue_empty,
	input  job_t      head_job,
	output logic      pop,
	output logic      b64_valid,
	input  logic      b64_ready,
	output out_word_t b64_word
);

	job_t      job_q;
	logic      busy_q;
	logic [1:0] idx_q;
	logic      out_valid_q;
	out_word_t out_q;

	logic      load_out;
	logic      emit;
	logic      final_word;
	out_word_t word;
	logic [5:0] sext;

	assign load_out   = !out_valid_q || b64_ready;
	assign emit       = busy_q && load_out;
	assign final_word = job_q.is_err || (idx_q == 2'd3);
	assign pop        = !queue_empty && (!busy_q || (emit && final_word));

	always_comb begin
		case (idx_q)
			2'd0:    sext = job_q.group[23:18];
			2'd1:    sext = job_q.group[17:12];
			2'd2:    sext = job_q.group[11:6];
			default: sext = job_q.group[5:0];
		endcase
		word.out_char        = b64_char(sext);
		word.last_of_message = 1'b0;
		word.status          = STATUS_OK;
		if (job_q.is_err) begin
			word.out_char        = 8'd0;
			word.last_of_message = 1'b1;
			word.status          = job_q.status;
		end else begin
			if ((idx_q == 2'd2 && job_q.pad_count == 2'd2) ||
			    (idx_q == 2'd3 && job_q.pad_count != 2'd0)) begin
				word.out_char = PAD_CHAR;
			end
			word.last_of_message = (idx_q == 2'd3) && job_q.last;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
		if (emit) begin
			out_q <= word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= 2'd0;
			end else if (emit) begin
				if (final_word) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
			if (load_out) begin
				out_valid_q <= emit;
			end
		end
	end

	assign b64_valid = out_valid_q;
	assign b64_word  = out_q;

endmodule

FILE: rtl/hex_to_base64_stream.sv
// Streaming hex to Base64 converter, top level. Depends on h2b_pkg, h2b_front,
// h2b_queue and h2b_back. A job from the front end is registered into a queue entry,
// then into the back end's job register, and its words into the output register.
// Throughput: one hex word per cycle in and one Base64 word per cycle out; the output
// port sets the pace, and the four-entry job queue holds hex_ready low only when it fills.
// Reset (arst_n low) clears all grouping state, the queue and the output register at once.
module hex_to_base64_stream import h2b_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      hex_valid,
	output logic      hex_ready,
	input  in_word_t  hex_word,
	output logic      b64_valid,
	input  logic      b64_ready,
	output out_word_t b64_word
);

	// The front end turns each accepted hex word into at most one job: a full
	// three-byte group, a padded group at message end, or an error word.
	logic queue_full;
	logic queue_empty;
	logic push;
	logic pop;
	job_t push_job;
	job_t head_job;

	h2b_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.hex_valid  (hex_valid),
		.hex_ready  (hex_ready),
		.hex_word   (hex_word),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	// The queue decouples the two halves so a stalled output does not stop
	// input until several jobs are waiting.
	h2b_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (queue_full),
		.pop      (pop),
		.head_job (head_job),
		.empty    (queue_empty)
	);

	// The back end expands each job into one to four registered output words,
	// and loads the next job in the same cycle that the last word goes out.
	h2b_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.head_job    (head_job),
		.pop         (pop),
		.b64_valid   (b64_valid),
		.b64_ready   (b64_ready),
		.b64_word    (b64_word)
	);

endmodule

FILE: rtl/h2b_port_checker.sv
// Port-level checks on the hex to Base64 converter, bound to the top level.
// Depends on h2b_pkg and hex_to_base64_stream.
module h2b_port_checker import h2b_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      hex_valid,
	input logic      hex_ready,
	input in_word_t  hex_word,
	input logic      b64_valid,
	input logic      b64_ready,
	input out_word_t b64_word
);

	// A hex word that waits for the block holds steady.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hex_valid && !hex_ready |=> hex_valid && $stable(hex_word))
		else $error("input word changed while stalled");

	// A stalled output word holds steady.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		b64_valid && !b64_ready |=> b64_valid && $stable(b64_word))
		else $error("output word changed while stalled");

	// A first padding character that is taken is followed at once by the last one.
	a_pad_pair: assert property (@(posedge clk) disable iff (!arst_n)
		b64_valid && b64_ready && b64_word.out_char == PAD_CHAR &&
		!b64_word.last_of_message
		|=> b64_valid && b64_word.out_char == PAD_CHAR && b64_word.last_of_message)
		else $error("padding pair broken");

	// Error words close a message and carry no character.
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		b64_valid && b64_word.status != STATUS_OK
		|-> b64_word.last_of_message && b64_word.out_char == 8'd0)
		else $error("malformed error word");

	// No output word is offered right after reset.
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !b64_valid)
		else $error("output valid after reset");

endmodule

bind hex_to_base64_stream h2b_port_checker u_port_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.hex_valid (hex_valid),
	.hex_ready (hex_ready),
	.hex_word  (hex_word),
	.b64_valid (b64_valid),
	.b64_ready (b64_ready),
	.b64_word  (b64_word)
);
